@@ sv/cmh_pkg.sv @@
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; every other file references this package by scoped names.
`default_nettype none
package cmh_pkg;

  // input transaction: raw magnetometer bytes plus second status byte
  typedef struct packed {
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] status_two;
  } cmh_in_t;

  // output transaction
  typedef struct packed {
    logic signed [8:0] heading_degrees;
    logic [1:0]        result_status;
  } cmh_out_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_SPAN     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_X_MAX = 2'd0,
    REG_X_MIN = 2'd1,
    REG_Y_MAX = 2'd2,
    REG_Y_MIN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] x_max;
    logic signed [15:0] x_min;
    logic signed [15:0] y_max;
    logic signed [15:0] y_min;
  } cfg_t;

  localparam int CORDIC_STEPS = 20;
  localparam int NORM_STEPS   = 6;    // shifts of 32,16,8,4,2,1
  localparam int AB_W         = 44;   // vector components during rotation
  localparam int Z_W          = 34;   // angle accumulator, binary angle units
  localparam int M_W          = 41;   // normalized magnitude: [2^40, 2^41) or zero
  localparam int STEP_W       = 5;
  localparam int NSTEP_W      = 3;
  localparam int DEG_SHIFT    = 52;
  localparam int MULT_W       = 29;
  localparam int P_W          = Z_W - 1 + MULT_W;
  localparam int D_W          = P_W - DEG_SHIFT;

  localparam logic [MULT_W-1:0]    DEG_MULT     = 29'd377486477;
  localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic [D_W-1:0]       HEADING_MAX  = 10'd180;

  // atan(2^-k) in binary angle units, 2^32 per turn
  localparam logic [31:0] ATAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // data handed from cell to cell
  typedef struct packed {
    logic signed [AB_W-1:0] a;
    logic signed [AB_W-1:0] b;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             status;
    logic                   zero;
  } cell_t;

  typedef struct packed {
    cell_t          core;
    logic [M_W-1:0] m;
  } norm_t;

  function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] k);
    return ATAN_BAM[k];
  endfunction

endpackage
`default_nettype wire

@@ sv/cmh_front.sv @@
// Front end: byte assembly and hard-iron correction, cross products, quadrant fold.
// Three registered stages with per-stage valid/ready. Uses cmh_pkg.
`default_nettype none
module cmh_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmh_pkg::cfg_t     cfg,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire cmh_pkg::cmh_in_t  up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output cmh_pkg::norm_t         dn_data
);

  // stage 0 registers
  logic              v0;
  logic signed [17:0] dx, dy;
  logic signed [16:0] sx, sy;
  logic [1:0]        st0;
  // stage 1 registers
  logic              v1;
  logic signed [34:0] num, den;
  logic [1:0]        st1;
  // stage 2 register
  logic              v2;

  logic rdy0, rdy1, rdy2;

  assign rdy2     = !v2 || dn_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign up_ready = rdy0;
  assign dn_valid = v2;

  // stage 0 logic
  logic signed [15:0] xr, yr;
  logic signed [16:0] xsum, ysum, xoff, yoff;
  logic signed [16:0] sx_c, sy_c;
  logic [1:0]         st0_c;

  always_comb begin
    xr   = {up_data.x_high_byte, up_data.x_low_byte};
    yr   = {up_data.y_high_byte, up_data.y_low_byte};
    xsum = {cfg.x_max[15], cfg.x_max} + {cfg.x_min[15], cfg.x_min};
    ysum = {cfg.y_max[15], cfg.y_max} + {cfg.y_min[15], cfg.y_min};
    // divide by two truncating toward zero
    xoff = (xsum + $signed({16'd0, xsum[16]})) >>> 1;
    yoff = (ysum + $signed({16'd0, ysum[16]})) >>> 1;
    sx_c = {cfg.x_max[15], cfg.x_max} - {cfg.x_min[15], cfg.x_min};
    sy_c = {cfg.y_max[15], cfg.y_max} - {cfg.y_min[15], cfg.y_min};
    if (up_data.status_two[3]) begin
      st0_c = cmh_pkg::STATUS_OVERFLOW;
    end else if (sx_c[16] || sx_c == '0 || sy_c[16] || sy_c == '0) begin
      st0_c = cmh_pkg::STATUS_SPAN;
    end else begin
      st0_c = cmh_pkg::STATUS_OK;
    end
  end

  // stage 2 logic: fold left half-plane onto the right one
  logic signed [34:0]          ra, rb;
  logic [34:0]                 rb_mag, m_c;
  logic signed [cmh_pkg::Z_W-1:0] z_c;

  always_comb begin
    if (den[34]) begin
      if (!num[34]) begin
        ra  = num;
        rb  = -den;
        z_c = cmh_pkg::QUARTER_TURN;
      end else begin
        ra  = -num;
        rb  = den;
        z_c = -cmh_pkg::QUARTER_TURN;
      end
    end else begin
      ra  = den;
      rb  = num;
      z_c = '0;
    end
    rb_mag = rb[34] ? 35'(-rb) : 35'(rb);
    m_c    = (35'(ra) > rb_mag) ? 35'(ra) : rb_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= up_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && up_valid) begin
      dx  <= {{2{xr[15]}}, xr} - {xoff[16], xoff};
      dy  <= {{2{yr[15]}}, yr} - {yoff[16], yoff};
      sx  <= sx_c;
      sy  <= sy_c;
      st0 <= st0_c;
    end
    if (rdy1 && v0) begin
      num <= 35'(dx) * 35'(sy);
      den <= 35'(dy) * 35'(sx);
      st1 <= st0;
    end
    if (rdy2 && v1) begin
      dn_data.core.a      <= cmh_pkg::AB_W'(ra);
      dn_data.core.b      <= cmh_pkg::AB_W'(rb);
      dn_data.core.z      <= z_c;
      dn_data.core.status <= st1;
      dn_data.core.zero   <= (num == '0) && (den == '0);
      dn_data.m           <= cmh_pkg::M_W'(m_c);
    end
  end

endmodule
`default_nettype wire

@@ sv/cmh_norm_cell.sv @@
// One normalization cell: shifts the vector left by 32 >> step when the magnitude
// leaves room for it. Six in a row bring m into [2^40, 2^41) unless zero. Uses cmh_pkg.
`default_nettype none
module cmh_norm_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [cmh_pkg::NSTEP_W-1:0] step,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire cmh_pkg::norm_t              up_data,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output cmh_pkg::norm_t                   dn_data
);

  logic       v;
  logic [5:0] sh, lim;
  logic       fits;
  cmh_pkg::norm_t nxt;

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;

  always_comb begin
    sh   = 6'd32 >> step;
    lim  = 6'(cmh_pkg::M_W) - sh;
    fits = (up_data.m >> lim) == '0;
    nxt  = up_data;
    if (fits) begin
      nxt.m      = up_data.m << sh;
      nxt.core.a = up_data.core.a <<< sh;
      nxt.core.b = up_data.core.b <<< sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/cmh_cordic_cell.sv @@
// One CORDIC vectoring iteration: rotates by atan(2^-step) toward the x axis
// and accumulates the angle. Uses cmh_pkg.
`default_nettype none
module cmh_cordic_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [cmh_pkg::STEP_W-1:0] step,
  input  wire logic                       up_valid,
  output logic                            up_ready,
  input  wire cmh_pkg::cell_t             up_data,
  output logic                            dn_valid,
  input  wire logic                       dn_ready,
  output cmh_pkg::cell_t                  dn_data
);

  logic v;
  logic signed [cmh_pkg::AB_W-1:0] sa, sb;
  logic signed [cmh_pkg::Z_W-1:0]  ang;
  cmh_pkg::cell_t nxt;

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;

  always_comb begin
    sa  = up_data.a >>> step;
    sb  = up_data.b >>> step;
    ang = cmh_pkg::Z_W'(cmh_pkg::atan_bam(step));
    nxt = up_data;
    if (!up_data.b[cmh_pkg::AB_W-1]) begin
      nxt.a = up_data.a + sb;
      nxt.b = up_data.b - sa;
      nxt.z = up_data.z + ang;
    end else begin
      nxt.a = up_data.a - sb;
      nxt.b = up_data.b + sa;
      nxt.z = up_data.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/cmh_back.sv @@
// Back end: angle to whole degrees (one multiply stage, one clamp/sign stage).
// The second stage is the output register. Uses cmh_pkg.
`default_nettype none
module cmh_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire cmh_pkg::cell_t   up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output cmh_pkg::cmh_out_t     dn_data
);

  logic                  va, vb;
  logic                  rdya, rdyb;
  logic [cmh_pkg::P_W-1:0] prod;
  logic                  neg, zero;
  logic [1:0]            st;

  logic [cmh_pkg::Z_W-2:0] mag;
  logic [cmh_pkg::D_W-1:0] d, dc;
  logic signed [8:0]       hdg;

  assign rdyb     = !vb || dn_ready;
  assign rdya     = !va || rdyb;
  assign up_ready = rdya;
  assign dn_valid = vb;

  always_comb begin
    mag = up_data.z[cmh_pkg::Z_W-1] ? (cmh_pkg::Z_W-1)'(-up_data.z)
                                    : (cmh_pkg::Z_W-1)'(up_data.z);
    d   = prod[cmh_pkg::P_W-1 -: cmh_pkg::D_W];
    dc  = (d > cmh_pkg::HEADING_MAX) ? cmh_pkg::HEADING_MAX : d;
    if (st != cmh_pkg::STATUS_OK || zero) begin
      hdg = '0;
    end else if (neg) begin
      hdg = -9'(dc);
    end else begin
      hdg = 9'(dc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdya) va <= up_valid;
      if (rdyb) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdya && up_valid) begin
      prod <= cmh_pkg::P_W'(mag) * cmh_pkg::P_W'(cmh_pkg::DEG_MULT);
      neg  <= up_data.z[cmh_pkg::Z_W-1];
      zero <= up_data.zero;
      st   <= up_data.status;
    end
    if (rdyb && va) begin
      dn_data.heading_degrees <= hdg;
      dn_data.result_status   <= st;
    end
  end

endmodule
`default_nettype wire

@@ sv/compass_heading_from_magnetometer.sv @@
// Top level of the calibrated compass heading block: config registers and the cell chain.
// Depends on cmh_pkg, cmh_front, cmh_norm_cell, cmh_cordic_cell, cmh_back.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    in_data   (cmh_in_t)
//   out       source     out_valid/out_ready  out_data  (cmh_out_t)
//   cfg       sink       cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready stays high. Data passes through
// cmh_front, the NORM_STEPS and CORDIC_STEPS cells (one CORDIC iteration each), cmh_back.
// Synchronous reset clears all valid bits and the calibration registers to zero.
// Each cell's ready ripples back from the output; a stalled output fills bubbles first
// and only then holds off in_ready.
`default_nettype none
module compass_heading_from_magnetometer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cmh_pkg::cmh_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cmh_pkg::cmh_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata
);

  cmh_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cmh_pkg::REG_X_MAX: cfg.x_max <= cfg_wdata;
        cmh_pkg::REG_X_MIN: cfg.x_min <= cfg_wdata;
        cmh_pkg::REG_Y_MAX: cfg.y_max <= cfg_wdata;
        cmh_pkg::REG_Y_MIN: cfg.y_min <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic           nv [cmh_pkg::NORM_STEPS+1];
  logic           nr [cmh_pkg::NORM_STEPS+1];
  cmh_pkg::norm_t nd [cmh_pkg::NORM_STEPS+1];

  logic           cv [cmh_pkg::CORDIC_STEPS+1];
  logic           cr [cmh_pkg::CORDIC_STEPS+1];
  cmh_pkg::cell_t cd [cmh_pkg::CORDIC_STEPS+1];

  cmh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (nv[0]),
    .dn_ready (nr[0]),
    .dn_data  (nd[0])
  );

  for (genvar i = 0; i < cmh_pkg::NORM_STEPS; i++) begin : g_norm
    cmh_norm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (cmh_pkg::NSTEP_W'(i)),
      .up_valid (nv[i]),
      .up_ready (nr[i]),
      .up_data  (nd[i]),
      .dn_valid (nv[i+1]),
      .dn_ready (nr[i+1]),
      .dn_data  (nd[i+1])
    );
  end

  assign cv[0] = nv[cmh_pkg::NORM_STEPS];
  assign cd[0] = nd[cmh_pkg::NORM_STEPS].core;
  assign nr[cmh_pkg::NORM_STEPS] = cr[0];

  for (genvar k = 0; k < cmh_pkg::CORDIC_STEPS; k++) begin : g_cordic
    cmh_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (cmh_pkg::STEP_W'(k)),
      .up_valid (cv[k]),
      .up_ready (cr[k]),
      .up_data  (cd[k]),
      .dn_valid (cv[k+1]),
      .dn_ready (cr[k+1]),
      .dn_data  (cd[k+1])
    );
  end

  cmh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cv[cmh_pkg::CORDIC_STEPS]),
    .up_ready (cr[cmh_pkg::CORDIC_STEPS]),
    .up_data  (cd[cmh_pkg::CORDIC_STEPS]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sv/cmh_checker.sv @@
// Port-level checker for the compass heading block, bound to the top level.
// Depends on cmh_pkg and the top level's port list.
`default_nettype none
module cmh_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire cmh_pkg::cmh_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // any error status forces a zero heading
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_status != cmh_pkg::STATUS_OK
      |-> out_data.heading_degrees == 9'sd0)
    else $error("nonzero heading with error status");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.heading_degrees <= 9'sd180 && out_data.heading_degrees >= -9'sd180
               && out_data.result_status != 2'd3)
    else $error("heading or status out of range");

endmodule

bind compass_heading_from_magnetometer cmh_checker u_checker (.*);
`default_nettype wire
